// ----- src/pvm_pkg.sv -----
// Shared types and constants for the PCM voice mixer.
`timescale 1ns / 1ps

package pvm_pkg;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_PLAY        = 3'd1,
    REQ_MUSIC_START = 3'd2,
    REQ_MUSIC_STOP  = 3'd3,
    REQ_DESC        = 3'd4,
    REQ_SAMPLE      = 3'd5
  } req_t;

  localparam logic [17:0] MAX_CLIP_LEN = 18'd131072;
  localparam logic [2:0]  MUSIC_CLIP_RESET = 3'd7;

  // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for x below 2**23
  localparam int          DIV5_MUL_W = 23;
  localparam int          DIV5_SHIFT = 25;
  localparam logic [22:0] DIV5_MUL   = 23'd6710887;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sat;
  } scale_res_t;

endpackage

// ----- src/pvm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pvm_scale.sv -----
// Scale of the mix sum by 4/5 toward zero with 16-bit saturation, three stages.
`timescale 1ns / 1ps

module pvm_scale #(
  parameter int MIX_W = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic signed [MIX_W-1:0] acc,
  output logic                   done,
  output pvm_pkg::scale_res_t    res
);
  import pvm_pkg::*;

  localparam int X_W = MIX_W + 2;
  localparam int P_W = X_W + DIV5_MUL_W;

  logic             v1, v2;
  logic             neg1, neg2;
  logic [X_W-1:0]   x1;
  logic [P_W-1:0]   prod2;
  logic [MIX_W-1:0] mag;
  logic [MIX_W-1:0] q;

  assign mag = acc[MIX_W-1] ? MIX_W'(-acc) : MIX_W'(acc);
  assign q   = prod2[DIV5_SHIFT +: MIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      v2   <= v1;
      done <= v2;
    end
    neg1  <= acc[MIX_W-1];
    x1    <= {mag, 2'b00};
    neg2  <= neg1;
    prod2 <= P_W'(x1) * P_W'(DIV5_MUL);
    if (neg2) begin
      if (q > MIX_W'(32768)) begin
        res.sample <= SAMPLE_MIN;
        res.sat    <= 1'b1;
      end else begin
        res.sample <= -signed'(q[15:0]);
        res.sat    <= 1'b0;
      end
    end else begin
      if (q > MIX_W'(32767)) begin
        res.sample <= SAMPLE_MAX;
        res.sat    <= 1'b1;
      end else begin
        res.sample <= signed'(q[15:0]);
        res.sat    <= 1'b0;
      end
    end
  end

endmodule

// ----- src/pcm_voice_mixer.sv -----
// Top level of the PCM voice mixer: request decode, voice sequencer and output register.
//
// Input beats on s_* carry one request each, kind in s_tuser. Play, music start/stop,
// descriptor and sample writes are done in S_IDLE. A tick walks the voices one per cycle
// through the sample RAM read port and one shared accumulator, then the music voice,
// then the 4/5 scaler, s_tready low until the result is loaded into the output register.
// Each tick yields one beat on m_* (mix, active voice count, saturation flag in
// m_tuser). The result sits in an output register, so non-tick requests are still
// taken while it waits; a second tick is taken, then holds s_tready low until it drains.
// cfg_* writes music_clip at any time, always ready; write it only while idle.
// Reset (rst, synchronous) clears descriptors, voices, music state and music_clip
// (to 7); the sample RAM is not cleared and must be written before it is played.
// SAMPLE_WORDS must be a power of two (unchecked); sample addresses wrap at SAMPLE_WORDS.
`timescale 1ns / 1ps

module pcm_voice_mixer #(
  parameter int VOICES       = 8,
  parameter int SAMPLE_WORDS = 131072,
  parameter int CLIP_SLOTS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // clip_index, address, clip_length, loop_flag, sample_value, pad
  input  logic [55:0] s_tdata,
  // req_type
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mixed_sample, active_voices, pad
  output logic [23:0] m_tdata,
  // saturated
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import pvm_pkg::*;

  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int CW    = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNTW  = $clog2(VOICES + 1);
  localparam int MIX_W = 16 + $clog2(VOICES + 1);

  typedef enum logic [2:0] {S_IDLE, S_VOICE, S_MUSIC, S_DRAIN, S_SCALE, S_OUT} state_t;

  state_t state;

  logic [16:0]  clip_start [CLIP_SLOTS];
  logic [17:0]  clip_len   [CLIP_SLOTS];
  logic         clip_loop  [CLIP_SLOTS];
  logic         voice_act  [VOICES];
  logic [CW-1:0] voice_clip [VOICES];
  logic [16:0]  voice_pos  [VOICES];
  logic [VW-1:0] ptr;
  logic         music_on;
  logic [16:0]  music_pos;
  logic [2:0]   music_clip;

  logic [VW-1:0]   vi;
  logic [CNTW-1:0] count;
  logic signed [MIX_W-1:0] acc;
  logic            rd_pending;
  logic            sc_go;
  logic            sc_done;
  scale_res_t      sc_res;
  scale_res_t      res_hold;

  req_t        in_req;
  logic [2:0]  in_clip;
  logic [16:0] in_addr;
  logic [17:0] in_len;
  logic        in_loop;
  logic [15:0] in_sval;
  logic        accept;

  logic [CW+2:0] in_clip_wide, music_clip_wide;
  logic [CW-1:0] in_idx, music_idx, tab_idx;
  logic          in_clip_ok, music_ok;
  logic [16:0]   tab_start;
  logic [17:0]   tab_len;
  logic          tab_loop;
  logic [16:0]   pos_sel;
  logic [17:0]   pos_inc;
  logic          wrap;
  logic          v_act_next;
  logic [17:0]   rsum;
  logic [AW+17:0] raddr_wide;
  logic [AW+16:0] waddr_wide;
  logic          ram_we, ram_re;
  logic signed [15:0] ram_rdata;
  logic [CNTW+3:0] cnt_wide;

  assign in_req  = req_t'(s_tuser);
  assign in_clip = s_tdata[2:0];
  assign in_addr = s_tdata[19:3];
  assign in_len  = s_tdata[37:20];
  assign in_loop = s_tdata[38];
  assign in_sval = s_tdata[54:39];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign in_clip_wide    = {CW'(0), in_clip};
  assign music_clip_wide = {CW'(0), music_clip};
  assign in_idx          = in_clip_wide[CW-1:0];
  assign music_idx       = music_clip_wide[CW-1:0];
  assign in_clip_ok      = in_clip_wide < (CW+3)'(CLIP_SLOTS);
  assign music_ok        = music_clip_wide < (CW+3)'(CLIP_SLOTS);

  always_comb begin
    case (state)
      S_VOICE: tab_idx = voice_clip[vi];
      S_MUSIC: tab_idx = music_idx;
      default: tab_idx = in_idx;
    endcase
  end

  assign tab_start = clip_start[tab_idx];
  assign tab_len   = clip_len[tab_idx];
  assign tab_loop  = clip_loop[tab_idx];

  assign pos_sel    = (state == S_MUSIC) ? music_pos : voice_pos[vi];
  assign pos_inc    = {1'b0, pos_sel} + 18'd1;
  assign wrap       = pos_inc >= tab_len;
  assign v_act_next = wrap ? tab_loop : 1'b1;

  assign rsum       = {1'b0, tab_start} + {1'b0, pos_sel};
  assign raddr_wide = {AW'(0), rsum};
  assign waddr_wide = {AW'(0), in_addr};

  assign ram_we = accept && (in_req == REQ_SAMPLE);
  assign ram_re = (tab_len != 18'd0) &&
                  (((state == S_VOICE) && voice_act[vi]) ||
                   ((state == S_MUSIC) && music_on && music_ok));

  pvm_ram #(
    .WIDTH(16),
    .DEPTH(SAMPLE_WORDS)
  ) u_sample_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_wide[AW-1:0]),
    .wdata(in_sval),
    .re   (ram_re),
    .raddr(raddr_wide[AW-1:0]),
    .rdata(ram_rdata)
  );

  pvm_scale #(
    .MIX_W(MIX_W)
  ) u_scale (
    .clk (clk),
    .rst (rst),
    .go  (sc_go),
    .acc (acc),
    .done(sc_done),
    .res (sc_res)
  );

  assign cnt_wide = {4'b0000, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      for (int i = 0; i < CLIP_SLOTS; i++) begin
        clip_start[i] <= '0;
        clip_len[i]   <= '0;
        clip_loop[i]  <= 1'b0;
      end
      for (int i = 0; i < VOICES; i++) begin
        voice_act[i]  <= 1'b0;
        voice_clip[i] <= '0;
        voice_pos[i]  <= '0;
      end
      ptr        <= '0;
      music_on   <= 1'b0;
      music_pos  <= '0;
      music_clip <= MUSIC_CLIP_RESET;
      vi         <= '0;
      count      <= '0;
      acc        <= '0;
      rd_pending <= 1'b0;
      sc_go      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        music_clip <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      rd_pending <= ram_re;
      sc_go      <= (state == S_DRAIN);
      if (rd_pending) begin
        acc <= acc + MIX_W'(ram_rdata);
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            case (in_req)
              REQ_TICK: begin
                vi    <= '0;
                count <= '0;
                acc   <= '0;
                state <= S_VOICE;
              end
              REQ_PLAY: begin
                if (in_clip_ok && (tab_len != 18'd0)) begin
                  voice_clip[ptr] <= in_idx;
                  voice_pos[ptr]  <= '0;
                  voice_act[ptr]  <= 1'b1;
                  ptr <= (ptr == VW'(VOICES - 1)) ? '0 : ptr + VW'(1);
                end
              end
              REQ_MUSIC_START: begin
                music_on  <= 1'b1;
                music_pos <= '0;
              end
              REQ_MUSIC_STOP: begin
                music_on  <= 1'b0;
                music_pos <= '0;
              end
              REQ_DESC: begin
                if (in_clip_ok) begin
                  clip_start[in_idx] <= in_addr;
                  clip_len[in_idx]   <= (in_len > MAX_CLIP_LEN) ? MAX_CLIP_LEN : in_len;
                  clip_loop[in_idx]  <= in_loop;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_VOICE: begin
          if (voice_act[vi]) begin
            if (tab_len == 18'd0) begin
              voice_act[vi] <= 1'b0;
              voice_pos[vi] <= '0;
            end else begin
              voice_pos[vi] <= wrap ? 17'd0 : pos_inc[16:0];
              voice_act[vi] <= v_act_next;
              count         <= count + CNTW'(v_act_next);
            end
          end
          if (vi == VW'(VOICES - 1)) begin
            state <= S_MUSIC;
          end else begin
            vi <= vi + VW'(1);
          end
        end
        S_MUSIC: begin
          if (ram_re) begin
            music_pos <= wrap ? 17'd0 : pos_inc[16:0];
          end
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (sc_done) begin
            res_hold <= sc_res;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata[15:0] <= res_hold.sample;
            m_tdata[19:16] <= (cnt_wide > (CNTW+4)'(15)) ? 4'd15 : cnt_wide[3:0];
            m_tdata[23:20] <= 4'd0;
            m_tuser[0]    <= res_hold.sat;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && in_req == REQ_TICK) |=> !s_tready)
    else $error("tick accepted but block still ready");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= VW'(VOICES - 1))
    else $error("voice pointer out of range");

  a_read_in_tick: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == S_VOICE || state == S_MUSIC || state == S_DRAIN))
    else $error("sample read outstanding outside a tick");

  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    sc_done |-> state == S_SCALE)
    else $error("scaler result with no tick waiting");

endmodule
